>>> sv/assert_macros.svh
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AOFI_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("aofi: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define AOFI_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("aofi: assertion failed");

`endif

>>> sv/aofi_pkg.sv
package aofi_pkg;

    typedef enum logic [1:0] {
        REQ_READ  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_TICK  = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_LOAD
    } t_state;

    // Register byte offsets.
    localparam logic [11:0] OFF_ENABLE  = 12'h000;
    localparam logic [11:0] OFF_CHAN    = 12'h004;
    localparam logic [11:0] OFF_MASK    = 12'h008;
    localparam logic [11:0] OFF_CHAN_RD = 12'h00C;
    localparam logic [11:0] OFF_RSVD0   = 12'h010;
    localparam logic [11:0] OFF_RSVD1   = 12'h014;
    localparam logic [11:0] OFF_RSVD2   = 12'h018;
    localparam logic [11:0] OFF_IRQ_ST  = 12'h01C;
    localparam logic [11:0] OFF_RSVD3   = 12'h020;
    localparam logic [11:0] OFF_IRQ_CLR = 12'h024;
    localparam logic [11:0] OFF_FIFO_ST = 12'h028;
    localparam logic [11:0] OFF_RSVD4   = 12'h02C;
    localparam logic [11:0] OFF_RATE    = 12'h038;
    localparam logic [11:0] OFF_DUMMY   = 12'h040;
    localparam logic [11:0] OFF_GAIN    = 12'h050;
    localparam logic [11:0] OFF_DATA    = 12'h060;

    localparam logic [4:0] STALL_RELOAD = 5'd24;

    typedef struct packed {
        logic capture;
        logic exec;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_status;

endpackage

>>> sv/audio_out_fifo_interface.sv
// Channel    Handshake                     Payload
// request    i_req_valid / o_req_ready     i_req_type, i_reg_offset, i_write_data
// response   o_rsp_valid / i_rsp_ready     o_read_data, o_access_error, o_irq_line,
//                                          o_dma_request, o_sample_valid, o_sample_out
//
// Each transaction passes through capture, execute (state update and
// sample memory read), and load into the output register.
// The controller sets the rate: the request is registered before it executes,
// and the registered sample read only completes at the execute edge.
// A finished response waits in the output register while the next request
// is taken; a stalled response holds the controller before its load step.
// Reset is synchronous and active low; the sample memory is not cleared.
`include "assert_macros.svh"

module audio_out_fifo_interface
    import aofi_pkg::*;
#(
    parameter int FIFO_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    output logic        o_req_ready,
    input  logic [1:0]  i_req_type,
    input  logic [11:0] i_reg_offset,
    input  logic [31:0] i_write_data,
    output logic        o_rsp_valid,
    input  logic        i_rsp_ready,
    output logic [31:0] o_read_data,
    output logic        o_access_error,
    output logic        o_irq_line,
    output logic        o_dma_request,
    output logic        o_sample_valid,
    output logic [31:0] o_sample_out
);

    t_cmd    w_cmd;
    t_status w_status;

    aofi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .i_status    (w_status),
        .o_req_ready (o_req_ready),
        .o_cmd       (w_cmd)
    );

    aofi_dp #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_req_type     (i_req_type),
        .i_reg_offset   (i_reg_offset),
        .i_write_data   (i_write_data),
        .i_rsp_ready    (i_rsp_ready),
        .o_rsp_valid    (o_rsp_valid),
        .o_read_data    (o_read_data),
        .o_access_error (o_access_error),
        .o_irq_line     (o_irq_line),
        .o_dma_request  (o_dma_request),
        .o_sample_valid (o_sample_valid),
        .o_sample_out   (o_sample_out)
    );

    // Only one transaction is in flight between capture and load.
    `AOFI_ASSERT_NXT(a_one_in_flight, i_clk, i_rst_n, i_req_valid && o_req_ready, !o_req_ready)
    // A drained sample never comes with an error.
    `AOFI_ASSERT_IMP(a_pop_no_err, i_clk, i_rst_n, o_rsp_valid && o_sample_valid, !o_access_error)
    // A drained sample never comes with read data.
    `AOFI_ASSERT_IMP(a_pop_no_rdata, i_clk, i_rst_n, o_rsp_valid && o_sample_valid, o_read_data == 32'd0)
    // Without a drained sample the sample field is zero.
    `AOFI_ASSERT_IMP(a_idle_sample, i_clk, i_rst_n, o_rsp_valid && !o_sample_valid, o_sample_out == 32'd0)

endmodule

>>> sv/aofi_ctrl.sv
module aofi_ctrl
    import aofi_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_req_valid,
    input  t_status i_status,
    output logic    o_req_ready,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_req_ready = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = ST_LOAD;
            end
            ST_LOAD: begin
                // Wait here until the output register can take the result.
                if (i_status.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

>>> sv/aofi_dp.sv
module aofi_dp
    import aofi_pkg::*;
#(
    parameter int FIFO_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_status     o_status,
    input  logic [1:0]  i_req_type,
    input  logic [11:0] i_reg_offset,
    input  logic [31:0] i_write_data,
    input  logic        i_rsp_ready,
    output logic        o_rsp_valid,
    output logic [31:0] o_read_data,
    output logic        o_access_error,
    output logic        o_irq_line,
    output logic        o_dma_request,
    output logic        o_sample_valid,
    output logic [31:0] o_sample_out
);

    localparam int AW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(FIFO_DEPTH);
    localparam logic [CW-1:0] HALF_CNT = CW'(FIFO_DEPTH / 2);
    localparam logic [CW-1:0] DMA_CNT  = CW'(FIFO_DEPTH - 4);
    localparam logic [AW-1:0] LAST_PTR = AW'(FIFO_DEPTH - 1);

    // Captured request.
    logic [1:0]  r_type;
    logic [11:0] r_off;
    logic [31:0] r_wdata;

    // Architectural state.
    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_fill, n_fill;
    logic          r_draining, n_draining;
    logic [4:0]    r_stall, n_stall;
    logic          r_block_en, n_block_en;
    logic [2:0]    r_chan, n_chan;
    logic          r_irq, n_irq;
    logic [15:0]   r_gain, n_gain;

    // Per-transaction results, settled in the execute cycle.
    logic        r_err, n_err;
    logic        r_pop, n_pop;
    logic [31:0] r_rdata, n_rdata;
    logic        n_push;

    logic [31:0] r_mem [FIFO_DEPTH];
    logic [31:0] r_mem_q;

    logic        r_out_valid;

    assign o_status.out_free = !r_out_valid || i_rsp_ready;
    assign o_rsp_valid       = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_type  <= i_req_type;
            r_off   <= i_reg_offset;
            r_wdata <= i_write_data;
        end
    end

    // Sample storage; the read port is sampled every execute cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && n_push) begin
            r_mem[r_tail] <= r_wdata;
        end
        if (i_cmd.exec) begin
            r_mem_q <= r_mem[r_head];
        end
    end

    always_comb begin
        n_head     = r_head;
        n_tail     = r_tail;
        n_fill     = r_fill;
        n_draining = r_draining;
        n_stall    = r_stall;
        n_block_en = r_block_en;
        n_chan     = r_chan;
        n_irq      = r_irq;
        n_gain     = r_gain;
        n_err      = 1'b0;
        n_pop      = 1'b0;
        n_push     = 1'b0;
        n_rdata    = '0;
        case (t_req'(r_type))
            REQ_READ: begin
                unique case (r_off)
                    OFF_ENABLE:  n_rdata = {31'd0, r_block_en};
                    OFF_CHAN_RD: n_rdata = {29'd0, r_chan};
                    OFF_IRQ_ST:  n_rdata = {31'd0, r_irq};
                    OFF_FIFO_ST: n_rdata = {26'd0, 1'b1, (r_fill < FULL_CNT), 4'd0};
                    OFF_DUMMY:   n_rdata = '0;
                    OFF_GAIN:    n_rdata = {16'd0, r_gain};
                    default:     n_err   = 1'b1;
                endcase
            end
            REQ_WRITE: begin
                unique case (r_off) inside
                    OFF_ENABLE: n_block_en = r_wdata[0];
                    OFF_CHAN: begin
                        n_chan = r_wdata[2:0];
                        if (!r_wdata[0]) begin
                            n_stall    = STALL_RELOAD;
                            n_draining = 1'b0;
                        end
                    end
                    OFF_IRQ_CLR: n_irq  = r_irq & r_wdata[0];
                    OFF_GAIN:    n_gain = r_wdata[15:0];
                    OFF_DATA: begin
                        if (r_fill == FULL_CNT) begin
                            n_err = 1'b1;
                        end else begin
                            n_push = 1'b1;
                            n_tail = (r_tail == LAST_PTR) ? '0 : r_tail + 1'b1;
                            n_fill = r_fill + 1'b1;
                            if (r_stall != '0) begin
                                n_stall = r_stall - 1'b1;
                            end
                            if (r_fill == '0) begin
                                n_draining = 1'b1;
                            end
                        end
                    end
                    // Mask, rate, dummy and reserved writes have no visible effect here;
                    // these writes complete without error.
                    OFF_MASK, OFF_RATE, OFF_DUMMY,
                    OFF_RSVD0, OFF_RSVD1, OFF_RSVD2, OFF_RSVD3, OFF_RSVD4: ;
                    default: n_err = 1'b1;
                endcase
            end
            REQ_TICK: begin
                if (r_draining && r_fill != '0) begin
                    n_pop  = 1'b1;
                    n_head = (r_head == LAST_PTR) ? '0 : r_head + 1'b1;
                    n_fill = r_fill - 1'b1;
                    if (n_fill == HALF_CNT) begin
                        n_irq = 1'b1;
                    end
                    if (n_fill == '0) begin
                        n_draining = 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head     <= '0;
            r_tail     <= '0;
            r_fill     <= '0;
            r_draining <= 1'b0;
            r_stall    <= '0;
            r_block_en <= 1'b0;
            r_chan     <= '0;
            r_irq      <= 1'b0;
            r_gain     <= '0;
        end else if (i_cmd.exec) begin
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_fill     <= n_fill;
            r_draining <= n_draining;
            r_stall    <= n_stall;
            r_block_en <= n_block_en;
            r_chan     <= n_chan;
            r_irq      <= n_irq;
            r_gain     <= n_gain;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_err   <= n_err;
            r_pop   <= n_pop;
            r_rdata <= n_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Status outputs reflect the state after the transaction.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            o_read_data    <= r_rdata;
            o_access_error <= r_err;
            o_irq_line     <= r_irq;
            o_dma_request  <= (r_stall == '0) && (r_fill <= DMA_CNT);
            o_sample_valid <= r_pop;
            o_sample_out   <= r_pop ? r_mem_q : '0;
        end
    end

endmodule

>>> bench/audio_out_fifo_interface_tb.sv
`timescale 1ns / 100ps

module audio_out_fifo_interface_tb;
    import aofi_pkg::*;

    localparam int AUDIO_FIFO_DEPTH = 64;
    localparam int PTR_W = $clog2(AUDIO_FIFO_DEPTH);
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_END = 1700;
    localparam int QUIET_END = 1820;
    localparam int HOLD_AT = 600;
    localparam int PAUSE_AT = 1100;
    localparam int IDLE_MIX [3] = '{0, 15, 40};
    localparam int TICK_MIX [3] = '{0, 10, 25};

    typedef struct packed {
        logic [31:0] rdata;
        logic        err;
        logic        irq;
        logic        dma;
        logic        sv;
        logic [31:0] sample;
    } t_audio_rsp;

    typedef struct packed {
        t_req        kind;
        logic [11:0] off;
        logic [31:0] data;
        logic        typed;
        t_audio_rsp  rsp;
    } t_stim_row;

    // Responses that follow directly from the reset state.
    localparam t_audio_rsp RSP_QUIET    = '{32'h0, 1'b0, 1'b0, 1'b1, 1'b0, 32'h0};
    localparam t_audio_rsp RSP_BAD_ADDR = '{32'h0, 1'b1, 1'b0, 1'b1, 1'b0, 32'h0};
    localparam t_audio_rsp RSP_EMPTY_ST = '{32'h30, 1'b0, 1'b0, 1'b1, 1'b0, 32'h0};
    localparam t_audio_rsp RSP_PREDICT  = '0;

    localparam t_stim_row DIRECTED_ROWS [25] = '{
        '{REQ_READ,  OFF_ENABLE,  32'h0,        1'b1, RSP_QUIET},
        '{REQ_READ,  OFF_FIFO_ST, 32'h0,        1'b1, RSP_EMPTY_ST},
        '{REQ_READ,  OFF_CHAN,    32'h0,        1'b1, RSP_BAD_ADDR},
        '{REQ_READ,  12'hFFF,     32'hFFFFFFFF, 1'b1, RSP_BAD_ADDR},
        '{REQ_WRITE, 12'hFFC,     32'hFFFFFFFF, 1'b1, RSP_BAD_ADDR},
        '{REQ_NONE,  12'hFFF,     32'hFFFFFFFF, 1'b1, RSP_QUIET},
        '{REQ_TICK,  12'h000,     32'h0,        1'b1, RSP_QUIET},
        '{REQ_WRITE, OFF_ENABLE,  32'hFFFFFFFF, 1'b0, RSP_PREDICT},
        '{REQ_READ,  OFF_ENABLE,  32'h0,        1'b0, RSP_PREDICT},
        '{REQ_WRITE, OFF_GAIN,    32'hFFFFFFFF, 1'b0, RSP_PREDICT},
        '{REQ_READ,  OFF_GAIN,    32'h0,        1'b0, RSP_PREDICT},
        '{REQ_WRITE, OFF_RATE,    32'hFFFFFFFF, 1'b0, RSP_PREDICT},
        '{REQ_WRITE, OFF_MASK,    32'hFFFFFFFF, 1'b0, RSP_PREDICT},
        '{REQ_WRITE, OFF_DUMMY,   32'hFFFFFFFF, 1'b0, RSP_PREDICT},
        '{REQ_READ,  OFF_DUMMY,   32'h0,        1'b0, RSP_PREDICT},
        '{REQ_WRITE, OFF_CHAN,    32'h0,        1'b0, RSP_PREDICT},
        '{REQ_READ,  OFF_CHAN_RD, 32'h0,        1'b0, RSP_PREDICT},
        '{REQ_WRITE, OFF_DATA,    32'hFFFFFFFF, 1'b0, RSP_PREDICT},
        '{REQ_WRITE, OFF_DATA,    32'h0,        1'b0, RSP_PREDICT},
        '{REQ_TICK,  12'hFFF,     32'hFFFFFFFF, 1'b0, RSP_PREDICT},
        '{REQ_TICK,  12'h000,     32'h0,        1'b0, RSP_PREDICT},
        '{REQ_TICK,  12'h000,     32'h0,        1'b0, RSP_PREDICT},
        '{REQ_WRITE, OFF_CHAN,    32'h7,        1'b0, RSP_PREDICT},
        '{REQ_WRITE, OFF_IRQ_CLR, 32'h0,        1'b0, RSP_PREDICT},
        '{REQ_READ,  OFF_IRQ_ST,  32'h0,        1'b0, RSP_PREDICT}
    };

    localparam logic [11:0] MAPPED_OFFSETS [16] = '{
        OFF_ENABLE, OFF_CHAN, OFF_MASK, OFF_CHAN_RD, OFF_RSVD0, OFF_RSVD1, OFF_RSVD2,
        OFF_IRQ_ST, OFF_RSVD3, OFF_IRQ_CLR, OFF_FIFO_ST, OFF_RSVD4, OFF_RATE,
        OFF_DUMMY, OFF_GAIN, OFF_DATA
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_req_valid;
    logic        o_req_ready;
    t_req        i_req_type;
    logic [11:0] i_reg_offset;
    logic [31:0] i_write_data;
    logic        o_rsp_valid;
    logic        i_rsp_ready;
    logic [31:0] o_read_data;
    logic        o_access_error;
    logic        o_irq_line;
    logic        o_dma_request;
    logic        o_sample_valid;
    logic [31:0] o_sample_out;

    // Expected-value override for directed rows, presented with the request.
    logic        row_typed;
    t_audio_rsp  row_rsp;

    // Predicted state of the audio output block.
    logic [31:0]      fifo_mem [AUDIO_FIFO_DEPTH];
    logic [PTR_W-1:0] fifo_rd_ptr = '0;
    logic [PTR_W-1:0] fifo_wr_ptr = '0;
    logic [PTR_W:0]   fifo_fill = '0;
    logic             drain_on = 1'b0;
    logic [4:0]       stall_count = '0;
    logic             enable_bit = 1'b0;
    logic [2:0]       chan_bits = '0;
    logic [31:0]      irq_mask = '0;
    logic             irq_pending = 1'b0;
    logic [8:0]       rate_code = '0;
    logic [15:0]      gain_word = '0;

    t_audio_rsp pending_responses [$];
    t_audio_rsp got_rsp;
    t_audio_rsp want_rsp;
    int         accepted_reqs = 0;
    int         stim_items = 0;
    int         error_count = 0;
    int         quiet_cycles = 0;
    int         req_idle_pct = 20;
    int         rsp_idle_pct = 20;
    bit         no_idle = 1'b0;
    bit         allow_stop = 1'b0;
    bit         long_hold_req = 1'b0;

    audio_out_fifo_interface #(.FIFO_DEPTH(AUDIO_FIFO_DEPTH)) u_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic fifo_push(logic [31:0] sample);
        if (fifo_fill >= AUDIO_FIFO_DEPTH)
            return 1'b0;
        fifo_mem[fifo_wr_ptr] = sample;
        fifo_wr_ptr = fifo_wr_ptr + 1'b1;
        fifo_fill = fifo_fill + 1'b1;
        if (stall_count != 0)
            stall_count = stall_count - 1'b1;
        if (fifo_fill == 1)
            drain_on = 1'b1;
        return 1'b1;
    endfunction

    function automatic t_audio_rsp next_audio_response(t_req kind, logic [11:0] off,
                                                       logic [31:0] data);
        t_audio_rsp r;
        r = '0;
        case (kind)
            REQ_READ: begin
                case (off)
                    OFF_ENABLE:  r.rdata = {31'd0, enable_bit};
                    OFF_CHAN_RD: r.rdata = {29'd0, chan_bits};
                    OFF_IRQ_ST:  r.rdata = {31'd0, irq_pending};
                    OFF_FIFO_ST: r.rdata = {26'd0, 1'b1, fifo_fill < AUDIO_FIFO_DEPTH, 4'd0};
                    OFF_DUMMY:   r.rdata = '0;
                    OFF_GAIN:    r.rdata = {16'd0, gain_word};
                    default:     r.err = 1'b1;
                endcase
            end
            REQ_WRITE: begin
                case (off)
                    OFF_ENABLE: enable_bit = data[0];
                    OFF_CHAN: begin
                        chan_bits = data[2:0];
                        if (!data[0]) begin
                            stall_count = STALL_RELOAD;
                            drain_on = 1'b0;
                        end
                    end
                    OFF_MASK:    irq_mask = data;
                    OFF_IRQ_CLR: irq_pending = irq_pending & data[0];
                    OFF_RATE:    rate_code = data[8:0];
                    OFF_GAIN:    gain_word = data[15:0];
                    OFF_DATA:    r.err = !fifo_push(data);
                    OFF_DUMMY, OFF_RSVD0, OFF_RSVD1, OFF_RSVD2, OFF_RSVD3, OFF_RSVD4: ;
                    default:     r.err = 1'b1;
                endcase
            end
            REQ_TICK: begin
                if (drain_on && fifo_fill != 0) begin
                    r.sample = fifo_mem[fifo_rd_ptr];
                    r.sv = 1'b1;
                    fifo_rd_ptr = fifo_rd_ptr + 1'b1;
                    fifo_fill = fifo_fill - 1'b1;
                    if (fifo_fill == AUDIO_FIFO_DEPTH / 2)
                        irq_pending = 1'b1;
                    if (fifo_fill == 0)
                        drain_on = 1'b0;
                end
            end
            default: ;
        endcase
        r.irq = irq_pending;
        r.dma = (stall_count == 0) && (fifo_fill <= AUDIO_FIFO_DEPTH - 4);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t: %s mismatch: got %h, expected %h", $time, what, got, want);
        error_count++;
    endtask

    task automatic check_response(t_audio_rsp got, t_audio_rsp want);
        if (got.rdata !== want.rdata)   report_mismatch("read_data", got.rdata, want.rdata);
        if (got.err !== want.err)       report_mismatch("access_error", got.err, want.err);
        if (got.irq !== want.irq)       report_mismatch("irq_line", got.irq, want.irq);
        if (got.dma !== want.dma)       report_mismatch("dma_request", got.dma, want.dma);
        if (got.sv !== want.sv)         report_mismatch("sample_valid", got.sv, want.sv);
        if (got.sample !== want.sample) report_mismatch("sample_out", got.sample, want.sample);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            quiet_cycles = quiet_cycles + 1;
            if (i_req_valid && o_req_ready) begin
                want_rsp = next_audio_response(i_req_type, i_reg_offset, i_write_data);
                pending_responses.push_back(row_typed ? row_rsp : want_rsp);
                accepted_reqs++;
                quiet_cycles = 0;
            end
            if (o_rsp_valid && i_rsp_ready) begin
                got_rsp = {o_read_data, o_access_error, o_irq_line, o_dma_request,
                           o_sample_valid, o_sample_out};
                quiet_cycles = 0;
                if (pending_responses.size() == 0)
                    report_mismatch("unexpected response", o_read_data, 32'h0);
                else
                    check_response(got_rsp, pending_responses.pop_front());
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Response side: random stalls, plus one long hold-off on request.
    initial begin
        i_rsp_ready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                i_rsp_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge i_clk);
                long_hold_req = 1'b0;
                i_rsp_ready <= 1'b1;
            end else if (!no_idle && $urandom_range(0, 99) < rsp_idle_pct) begin
                i_rsp_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(negedge i_clk);
                i_rsp_ready <= 1'b1;
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_request(t_req kind, logic [11:0] off, logic [31:0] data,
                                logic typed, t_audio_rsp rsp);
        int seen;
        if (!no_idle && $urandom_range(0, 99) < req_idle_pct) begin
            i_req_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        i_req_valid  <= 1'b1;
        i_req_type   <= kind;
        i_reg_offset <= off;
        i_write_data <= data;
        row_typed    <= typed;
        row_rsp      <= rsp;
        seen = accepted_reqs;
        do @(negedge i_clk); while (accepted_reqs == seen);
        if (kind != REQ_NONE)
            stim_items++;
    endtask

    // Disabling the channel with samples queued halts draining for good, so it
    // is only allowed when the FIFO is empty until the closing sequence.
    task automatic issue(t_req kind, logic [11:0] off, logic [31:0] data);
        if (kind == REQ_WRITE && off == OFF_CHAN && fifo_fill != 0 && !allow_stop)
            data[0] = 1'b1;
        send_request(kind, off, data, 1'b0, RSP_PREDICT);
    endtask

    task automatic random_scenario();
        int pick;
        int n;
        int tick_pct;
        logic [11:0] off;
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            // Fill and drain; large bursts can cross half full and reach full.
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 24);
            tick_pct = TICK_MIX[$urandom_range(0, 2)];
            repeat (n) begin
                if ($urandom_range(0, 99) < tick_pct)
                    issue(REQ_TICK, 12'($urandom), $urandom);
                else if ($urandom_range(0, 19) == 0)
                    issue(REQ_READ, OFF_FIFO_ST, $urandom);
                else
                    issue(REQ_WRITE, OFF_DATA, $urandom);
            end
            while (fifo_fill != 0) begin
                if ($urandom_range(0, 9) == 0)
                    issue(REQ_READ, OFF_IRQ_ST, $urandom);
                else
                    issue(REQ_TICK, 12'($urandom), $urandom);
            end
        end else if (pick < 50) begin
            repeat ($urandom_range(1, 8))
                issue($urandom_range(0, 1) ? REQ_WRITE : REQ_READ,
                      MAPPED_OFFSETS[$urandom_range(0, 15)], $urandom);
        end else if (pick < 60) begin
            issue(REQ_WRITE, OFF_CHAN, $urandom);
            issue(REQ_READ, OFF_CHAN_RD, $urandom);
        end else if (pick < 70) begin
            issue(REQ_READ, OFF_IRQ_ST, $urandom);
            issue(REQ_WRITE, OFF_IRQ_CLR, $urandom);
            issue(REQ_READ, OFF_IRQ_ST, $urandom);
        end else if (pick < 80) begin
            repeat ($urandom_range(1, 10))
                issue(REQ_TICK, 12'($urandom), $urandom);
        end else if (pick < 90) begin
            repeat ($urandom_range(1, 6)) begin
                if ($urandom_range(0, 1))
                    off = 12'($urandom);
                else
                    off = MAPPED_OFFSETS[$urandom_range(0, 15)] + 12'($urandom_range(1, 3));
                issue(t_req'($urandom_range(0, 3)), off, $urandom);
            end
        end else begin
            foreach (MAPPED_OFFSETS[i])
                issue(REQ_READ, MAPPED_OFFSETS[i], $urandom);
        end
    endtask

    initial begin
        int next_mix_at;
        bit hold_done;
        bit pause_done;
        next_mix_at = 0;
        hold_done = 1'b0;
        pause_done = 1'b0;
        i_rst_n = 1'b0;
        i_req_valid = 1'b0;
        i_req_type = REQ_NONE;
        i_reg_offset = '0;
        i_write_data = '0;
        row_typed = 1'b0;
        row_rsp = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (DIRECTED_ROWS[i])
            send_request(DIRECTED_ROWS[i].kind, DIRECTED_ROWS[i].off, DIRECTED_ROWS[i].data,
                         DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].rsp);

        while (stim_items < RANDOM_END) begin
            if (stim_items >= next_mix_at) begin
                req_idle_pct = IDLE_MIX[$urandom_range(0, 2)];
                rsp_idle_pct = IDLE_MIX[$urandom_range(0, 2)];
                next_mix_at += 150;
            end
            if (!hold_done && stim_items >= HOLD_AT) begin
                long_hold_req = 1'b1;
                hold_done = 1'b1;
            end
            if (!pause_done && stim_items >= PAUSE_AT) begin
                i_req_valid <= 1'b0;
                do @(negedge i_clk); while (pending_responses.size() != 0);
                pause_done = 1'b1;
            end
            random_scenario();
        end

        no_idle = 1'b1;
        while (stim_items < QUIET_END)
            random_scenario();

        // Stop draining with samples queued: later pushes must not restart it.
        allow_stop = 1'b1;
        repeat (12) issue(REQ_WRITE, OFF_DATA, $urandom);
        issue(REQ_WRITE, OFF_CHAN, $urandom & 32'hFFFF_FFFE);
        repeat (3) issue(REQ_WRITE, OFF_DATA, $urandom);
        repeat (4) issue(REQ_TICK, 12'($urandom), $urandom);
        while (fifo_fill < AUDIO_FIFO_DEPTH)
            issue(REQ_WRITE, OFF_DATA, $urandom);
        repeat (3) issue(REQ_WRITE, OFF_DATA, $urandom);
        issue(REQ_READ, OFF_FIFO_ST, $urandom);
        issue(REQ_WRITE, OFF_CHAN, 32'h7);
        repeat (3) issue(REQ_TICK, 12'($urandom), $urandom);
        issue(REQ_READ, OFF_IRQ_ST, $urandom);

        i_req_valid <= 1'b0;
        do @(negedge i_clk); while (pending_responses.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> files.f
+incdir+sv
sv/aofi_pkg.sv
sv/aofi_ctrl.sv
sv/aofi_dp.sv
sv/audio_out_fifo_interface.sv
bench/audio_out_fifo_interface_tb.sv
